@@ rtl/core/psh_pkg.sv @@
package psh_pkg;

    // Field widths fixed by the interface.
    localparam int NUM_CH    = 3;
    localparam int CH_W      = 2;
    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 7;
    localparam int PERIOD_W  = 16;
    localparam int TENTH_W   = 7;
    localparam int SCALED_W  = PERIOD_W + TENTH_W;

    // Milliseconds in one tenth of a second.
    localparam logic [TENTH_W-1:0] TENTH_MS = 7'd100;

    // Channel codes.
    localparam logic [CH_W-1:0] CH_LIGHT       = 2'd0;
    localparam logic [CH_W-1:0] CH_VOLTAGE     = 2'd1;
    localparam logic [CH_W-1:0] CH_TEMPERATURE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LIGHT_PERIOD       = 2'd0;
    localparam logic [1:0] REG_VOLTAGE_PERIOD     = 2'd1;
    localparam logic [1:0] REG_TEMPERATURE_PERIOD = 2'd2;

    // Input actions.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic {
        RD_IDLE,
        RD_RUN
    } rd_state_t;

    typedef struct packed {
        logic                valid;
        logic [1:0]          index;
        logic [PERIOD_W-1:0] data;
    } cfg_wr_t;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_vec_t;

endpackage

@@ rtl/core/periodic_sample_history.sv @@
// Three-channel sample history (light, voltage, temperature), each a ring of
// HISTORY_DEPTH 16-bit samples in its own memory. On a tick transaction, every
// channel whose period is nonzero and whose due time has come stores its
// reading. A read transaction of N samples (count saturated to the depth) shows
// them newest first via the memory read register and the output register, one
// sample per cycle while the output is taken; the one read port per
// memory sets that pace. The next input transaction is accepted in the cycle
// after the final memory read of a run is issued. Reset clears per-entry valid
// bits at once, so there is no clearing pass and never-written entries read zero.
module periodic_sample_history #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [psh_pkg::TIME_W-1:0]          now_ms,
    input  logic [psh_pkg::SAMPLE_W-1:0]        light_reading,
    input  logic [psh_pkg::SAMPLE_W-1:0]        voltage_reading,
    input  logic signed [psh_pkg::SAMPLE_W-1:0] temperature_reading,
    input  logic [psh_pkg::CH_W-1:0]            channel,
    input  logic [psh_pkg::CNT_W-1:0]           count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [psh_pkg::CH_W-1:0]            channel_out,
    output logic [psh_pkg::SAMPLE_W-1:0]        sample_value,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [psh_pkg::PERIOD_W-1:0]        cfg_data
);
    import psh_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    cfg_wr_t                  cfg;
    logic                     tick;
    logic                     start;
    logic                     busy;
    logic [NUM_CH-1:0]        we;
    logic [NUM_CH-1:0][AW-1:0] wptr;
    logic [NUM_CH-1:0]        rd_en;
    logic [AW-1:0]            raddr;
    sample_vec_t              reading;
    sample_vec_t              rdata;

    // Input transactions wait while a read run is still issuing memory reads.
    assign in_ready  = !busy;
    assign tick      = in_valid && in_ready && (action == ACT_TICK);
    assign start     = in_valid && in_ready && (action == ACT_READ);
    assign cfg_ready = 1'b1;

    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign reading[0] = light_reading;
    assign reading[1] = voltage_reading;
    assign reading[2] = $unsigned(temperature_reading);

    psh_tick #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW)
    ) u_tick (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .now_ms (now_ms),
        .we     (we),
        .wptr   (wptr)
    );

    // One sample memory per channel.
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_store
        psh_ram #(
            .DEPTH (HISTORY_DEPTH),
            .AW    (AW)
        ) u_ram (
            .clk   (clk),
            .rst_n (rst_n),
            .we    (we[c]),
            .waddr (wptr[c]),
            .wdata (reading[c]),
            .re    (rd_en[c]),
            .raddr (raddr),
            .rdata (rdata[c])
        );
    end

    psh_reader #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW),
        .CW            (CW)
    ) u_reader (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .channel      (channel),
        .count        (count),
        .wptr         (wptr),
        .rdata        (rdata),
        .busy         (busy),
        .rd_en        (rd_en),
        .raddr        (raddr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .channel_out  (channel_out),
        .sample_value (sample_value),
        .last         (last)
    );

`ifndef SYNTHESIS
    // Only one channel memory is read at a time.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(rd_en))
        else $error("more than one channel memory read at once");

    // A tick never writes a memory while a read run is issuing reads.
    assert property (@(posedge clk) disable iff (!rst_n) (|we) |-> (rd_en == '0))
        else $error("memory write overlaps a history read");

    // A shown sample always belongs to a real channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (channel_out <= CH_TEMPERATURE))
        else $error("sample shown for an undefined channel");

    // Memory reads happen only during a run, after which new items may enter.
    assert property (@(posedge clk) disable iff (!rst_n) (|rd_en) |-> !in_ready)
        else $error("memory read issued while input is accepted");
`endif

endmodule

@@ rtl/core/psh_ram.sv @@
module psh_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [psh_pkg::SAMPLE_W-1:0]  wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [psh_pkg::SAMPLE_W-1:0]  rdata
);
    import psh_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_vld_reg;

    // Sample storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Per-entry valid bits; an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_vld_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/psh_tick.sv @@
module psh_tick #(
    parameter int HISTORY_DEPTH = 64,
    parameter int AW            = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  psh_pkg::cfg_wr_t                      cfg,
    input  logic                                  tick,
    input  logic [psh_pkg::TIME_W-1:0]            now_ms,
    output logic [psh_pkg::NUM_CH-1:0]            we,
    output logic [psh_pkg::NUM_CH-1:0][AW-1:0]    wptr
);
    import psh_pkg::*;

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ch
        logic [SCALED_W-1:0] scaled_reg;
        logic [SCALED_W-1:0] scaled_next;
        logic [TIME_W-1:0]   last_reg;
        logic [TIME_W-1:0]   last_next;
        logic [AW-1:0]       wptr_reg;
        logic [AW-1:0]       wptr_next;
        logic [TIME_W-1:0]   due;
        logic                fire;

        // The period is kept in milliseconds, scaled when it is written.
        always_comb
        begin
            scaled_next = scaled_reg;
            if (cfg.valid && (cfg.index == 2'(c)))
            begin
                scaled_next = SCALED_W'(cfg.data) * SCALED_W'(TENTH_MS);
            end
        end

        // A channel samples once its due time, wrapping modulo 2^32, is reached.
        always_comb
        begin
            due       = last_reg + TIME_W'(scaled_reg);
            fire      = tick && (scaled_reg != '0) && (now_ms >= due);
            last_next = last_reg;
            wptr_next = wptr_reg;
            if (fire)
            begin
                last_next = now_ms;
                wptr_next = (wptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                scaled_reg <= '0;
                last_reg   <= '0;
                wptr_reg   <= '0;
            end
            else
            begin
                scaled_reg <= scaled_next;
                last_reg   <= last_next;
                wptr_reg   <= wptr_next;
            end
        end

        assign we[c]   = fire;
        assign wptr[c] = wptr_reg;
    end

endmodule

@@ rtl/core/psh_reader.sv @@
module psh_reader #(
    parameter int HISTORY_DEPTH = 64,
    parameter int AW            = 6,
    parameter int CW            = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [psh_pkg::CH_W-1:0]              channel,
    input  logic [psh_pkg::CNT_W-1:0]             count,
    input  logic [psh_pkg::NUM_CH-1:0][AW-1:0]    wptr,
    input  psh_pkg::sample_vec_t                  rdata,
    output logic                                  busy,
    output logic [psh_pkg::NUM_CH-1:0]            rd_en,
    output logic [AW-1:0]                         raddr,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [psh_pkg::CH_W-1:0]              channel_out,
    output logic [psh_pkg::SAMPLE_W-1:0]          sample_value,
    output logic                                  last
);
    import psh_pkg::*;

    rd_state_t           state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [CW-1:0]       remain_reg, remain_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [CH_W-1:0]     pend_ch_reg, pend_ch_next;
    logic                pend_last_reg, pend_last_next;
    logic                out_valid_reg, out_valid_next;
    logic [CH_W-1:0]     out_ch_reg, out_ch_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                out_last_reg, out_last_next;

    logic                load_out;
    logic                issue;
    logic [AW-1:0]       prev_ptr;
    logic [CW-1:0]       cnt_sat;
    logic [AW-1:0]       start_ptr;
    logic [SAMPLE_W-1:0] pend_data;

    // Select the pointer of the requested channel and the data of the pending one.
    always_comb
    begin
        case (channel)
            CH_LIGHT:       start_ptr = wptr[0];
            CH_VOLTAGE:     start_ptr = wptr[1];
            CH_TEMPERATURE: start_ptr = wptr[2];
            default:        start_ptr = '0;
        endcase
        case (pend_ch_reg)
            CH_LIGHT:       pend_data = rdata[0];
            CH_VOLTAGE:     pend_data = rdata[1];
            CH_TEMPERATURE: pend_data = rdata[2];
            default:        pend_data = '0;
        endcase
    end

    // Read sequencer: one memory read per cycle while the output is taken, newest entry first.
    always_comb
    begin
        load_out = pend_reg && (!out_valid_reg || out_ready);
        issue    = (state_reg == RD_RUN) && (!pend_reg || load_out);
        prev_ptr = (ptr_reg == '0) ? AW'(HISTORY_DEPTH - 1) : ptr_reg - 1'b1;
        cnt_sat  = (count > CNT_W'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH) : CW'(count);

        state_next      = state_reg;
        ch_next         = ch_reg;
        remain_next     = remain_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        pend_ch_next    = pend_ch_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg;
        out_ch_next     = out_ch_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        rd_en           = '0;

        case (state_reg)
            RD_IDLE:
            begin
                if (start && (channel <= CH_TEMPERATURE) && (count != '0))
                begin
                    state_next  = RD_RUN;
                    ch_next     = channel;
                    remain_next = cnt_sat;
                    ptr_next    = start_ptr;
                end
            end
            RD_RUN:
            begin
                if (issue)
                begin
                    rd_en[ch_reg]  = 1'b1;
                    ptr_next       = prev_ptr;
                    remain_next    = remain_reg - 1'b1;
                    pend_ch_next   = ch_reg;
                    pend_last_next = (remain_reg == CW'(1));
                    if (remain_reg == CW'(1))
                    begin
                        state_next = RD_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = RD_IDLE;
            end
        endcase

        // The read data register holds a sample until the output register takes it.
        if (issue)
        begin
            pend_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end

        // Output register.
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_ch_next     = pend_ch_reg;
            out_sample_next = pend_data;
            out_last_next   = pend_last_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RD_IDLE;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        ptr_reg        <= ptr_next;
        pend_ch_reg    <= pend_ch_next;
        pend_last_reg  <= pend_last_next;
        out_ch_reg     <= out_ch_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign busy         = (state_reg == RD_RUN);
    assign raddr        = prev_ptr;
    assign out_valid    = out_valid_reg;
    assign channel_out  = out_ch_reg;
    assign sample_value = out_sample_reg;
    assign last         = out_last_reg;

endmodule
